[rtl/core/amrnp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrnp_pkg: shared types and constants of the multi-radix number parser
// Word formats, parse phase codes, status codes and overflow limits.
// ----------------------------------------------------------------------------
package amrnp_pkg;

  typedef struct packed {
    logic       start_of_text;
    logic [7:0] character;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [7:0]  next_offset;
  } out_word_t;

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_SKIP = 8'b0000_0010,
    PH_ZERO = 8'b0000_0100,
    PH_HEX  = 8'b0000_1000,
    PH_OCT  = 8'b0001_0000,
    PH_BIN  = 8'b0010_0000,
    PH_DEC  = 8'b0100_0000,
    PH_DONE = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONUM = 2'd1,
    ST_OVF   = 2'd2
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] acc;
    logic [7:0]  pos;
    logic        digit_seen;
  } parse_state_t;

  localparam logic [31:0] DecLimit = 32'd429496729;
  localparam logic [31:0] HexMask  = 32'hF000_0000;
  localparam logic [31:0] OctMask  = 32'hE000_0000;
  localparam logic [31:0] BinMask  = 32'h8000_0000;
  localparam logic [31:0] OvfValue = 32'h00FF_FFFF;

endpackage

[rtl/core/amrnp_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrnp_step: next-state and result logic for one character
// Prefix detection, digit decode, overflow check and shift-add accumulate.
// ----------------------------------------------------------------------------
module amrnp_step (
  input  amrnp_pkg::parse_state_t state_i,
  input  amrnp_pkg::in_word_t     word_i,
  input  logic [7:0]              offset_cap_i,
  output amrnp_pkg::parse_state_t state_o,
  output logic                    emit_o,
  output amrnp_pkg::out_word_t    result_o
);

  amrnp_pkg::parse_state_t cur;
  logic [7:0]  c;
  logic [7:0]  p;
  logic        is_dec;
  logic        is_uhex;
  logic        is_lhex;
  logic [3:0]  dval;
  logic        dvalid;
  logic        ovf;
  logic [31:0] acc_next;

  assign c = word_i.character;

  // digit decode for the current radix
  always_comb begin
    is_dec  = c inside {[8'h30:8'h39]};
    is_uhex = c inside {[8'h41:8'h46]};
    is_lhex = c inside {[8'h61:8'h66]};
    dval    = 4'd0;
    dvalid  = 1'b0;
    if (is_dec) begin
      dval = c[3:0];
    end else if (is_uhex || is_lhex) begin
      dval = c[3:0] + 4'd9;
    end
    case (cur.phase)
      amrnp_pkg::PH_HEX: dvalid = is_dec || is_uhex || is_lhex;
      amrnp_pkg::PH_OCT: dvalid = is_dec && !dval[3];
      amrnp_pkg::PH_BIN: dvalid = is_dec && (dval[3:1] == 3'd0);
      amrnp_pkg::PH_DEC: dvalid = is_dec;
      default:           dvalid = 1'b0;
    endcase
  end

  // overflow check and accumulate
  always_comb begin
    case (cur.phase)
      amrnp_pkg::PH_HEX: begin
        ovf      = (cur.acc & amrnp_pkg::HexMask) != 32'd0;
        acc_next = {cur.acc[27:0], dval};
      end
      amrnp_pkg::PH_OCT: begin
        ovf      = (cur.acc & amrnp_pkg::OctMask) != 32'd0;
        acc_next = {cur.acc[28:0], dval[2:0]};
      end
      amrnp_pkg::PH_BIN: begin
        ovf      = (cur.acc & amrnp_pkg::BinMask) != 32'd0;
        acc_next = {cur.acc[30:0], dval[0]};
      end
      default: begin
        ovf      = (cur.acc > amrnp_pkg::DecLimit) ||
                   ((cur.acc == amrnp_pkg::DecLimit) && (dval > 4'd5));
        acc_next = {cur.acc[28:0], 3'b000} + {cur.acc[30:0], 1'b0} + {28'd0, dval};
      end
    endcase
  end

  always_comb begin
    cur = state_i;
    if (word_i.start_of_text) begin
      cur.phase      = amrnp_pkg::PH_SKIP;
      cur.acc        = 32'd0;
      cur.pos        = 8'd0;
      cur.digit_seen = 1'b0;
    end
    p        = cur.pos;
    state_o  = cur;
    emit_o   = 1'b0;
    result_o = '{value: 32'd0, status: amrnp_pkg::ST_NONUM, next_offset: 8'd0};

    if (cur.phase != amrnp_pkg::PH_IDLE && cur.phase != amrnp_pkg::PH_DONE) begin
      if (cur.pos < offset_cap_i) begin
        state_o.pos = cur.pos + 8'd1;
      end
      case (cur.phase)
        amrnp_pkg::PH_SKIP: begin
          if (c == 8'h00) begin
            emit_o = 1'b1;
          end else if (c <= 8'h20) begin
            // blank: skip
          end else if (c == 8'h30) begin
            state_o.phase = amrnp_pkg::PH_ZERO;
          end else if (c == 8'h62 || c == 8'h42) begin
            state_o.phase      = amrnp_pkg::PH_BIN;
            state_o.acc        = 32'd0;
            state_o.digit_seen = 1'b0;
          end else if (is_dec) begin
            state_o.phase      = amrnp_pkg::PH_DEC;
            state_o.acc        = {28'd0, c[3:0]};
            state_o.digit_seen = 1'b1;
          end else begin
            emit_o = 1'b1;
          end
        end
        amrnp_pkg::PH_ZERO: begin
          if (c == 8'h78 || c == 8'h58) begin
            state_o.phase      = amrnp_pkg::PH_HEX;
            state_o.acc        = 32'd0;
            state_o.digit_seen = 1'b0;
          end else if (c inside {[8'h30:8'h37]}) begin
            state_o.phase      = amrnp_pkg::PH_OCT;
            state_o.acc        = {28'd0, c[3:0]};
            state_o.digit_seen = 1'b1;
          end else begin
            // lone zero
            emit_o               = 1'b1;
            result_o.status      = amrnp_pkg::ST_OK;
            result_o.next_offset = p;
          end
        end
        default: begin
          if (!dvalid) begin
            emit_o = 1'b1;
            if (cur.digit_seen) begin
              result_o.value       = cur.acc;
              result_o.status      = amrnp_pkg::ST_OK;
              result_o.next_offset = p;
            end
          end else if (ovf) begin
            emit_o          = 1'b1;
            result_o.value  = amrnp_pkg::OvfValue;
            result_o.status = amrnp_pkg::ST_OVF;
          end else begin
            state_o.acc        = acc_next;
            state_o.digit_seen = 1'b1;
          end
        end
      endcase
      if (emit_o) begin
        state_o.phase = amrnp_pkg::PH_DONE;
      end
    end
  end

endmodule

[rtl/core/ascii_multi_radix_number_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_multi_radix_number_parser: strtoul-style 32-bit text number parser
// Takes one text byte per word and gives one result word per parsed text.
// ----------------------------------------------------------------------------
// Takes one character every clock cycle while no held result is stalled. A
// character sits in an input register while the combinational shift-add/compare
// update runs. When the character ends the number, the result is loaded from
// that update into the output register, where it is held until taken. The
// input stalls only while a held result is stalled and a character waits in the
// input register. Overflow returns 0xFFFFFF with status 2; the offset
// saturates at min(MAX_TEXT_LEN, 255).
module ascii_multi_radix_number_parser #(
  parameter int unsigned MAX_TEXT_LEN = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  amrnp_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output amrnp_pkg::out_word_t out_word_o
);

  localparam int unsigned CapInt = (MAX_TEXT_LEN < 255) ? MAX_TEXT_LEN : 255;
  localparam logic [7:0]  OffsetCap = CapInt[7:0];

  logic                    in_valid_q;
  amrnp_pkg::in_word_t     in_word_q;
  amrnp_pkg::parse_state_t state_q, state_d;
  logic                    out_valid_q;
  amrnp_pkg::out_word_t    out_word_q;
  logic                    emit;
  amrnp_pkg::out_word_t    result;
  logic                    proc_ready;
  logic                    proc_fire;

  assign proc_ready = !out_valid_q || !out_stall_i;
  assign proc_fire  = in_valid_q && proc_ready;
  assign in_stall_o = in_valid_q && !proc_ready;

  amrnp_step u_step (
    .state_i      (state_q),
    .word_i       (in_word_q),
    .offset_cap_i (OffsetCap),
    .state_o      (state_d),
    .emit_o       (emit),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: amrnp_pkg::PH_IDLE, acc: 32'd0, pos: 8'd0, digit_seen: 1'b0};
    end else if (proc_fire) begin
      state_q <= state_d;
    end
  end

  // drop the result once taken, load a new one when the character ends a number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_ready) begin
      out_valid_q <= proc_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && emit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[tb/sv/ascii_multi_radix_number_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_multi_radix_number_parser_tb: self-checking bench for the number parser
// Sends directed and random texts one character per word. A behavioral parser
// predicts each result word, and the results are checked in order, field by
// field, while sender gaps and receiver stalls vary across the run.
// ----------------------------------------------------------------------------
module ascii_multi_radix_number_parser_tb;

  localparam int unsigned MaxTextLen  = 255;
  localparam logic [7:0]  OffsetCap   = (MaxTextLen < 255) ? 8'(MaxTextLen) : 8'd255;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam string       HexDigits   = "0123456789abcdefABCDEF";

  typedef logic [7:0] text_q_t[$];

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  amrnp_pkg::in_word_t  in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  amrnp_pkg::out_word_t out_word_o;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned words_sent         = 0;
  int unsigned cycle_count        = 0;
  int          error_count        = 0;

  amrnp_pkg::out_word_t expected_results[$];

  // behavioral parser state
  amrnp_pkg::phase_e number_phase = amrnp_pkg::PH_IDLE;
  logic [31:0]       number_acc   = '0;
  logic [7:0]        text_pos     = '0;
  logic              have_digit   = 1'b0;

  ascii_multi_radix_number_parser #(
    .MAX_TEXT_LEN(MaxTextLen)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int digit_of_char(input logic [7:0] c, input int unsigned radix);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = int'(c - "0");
    else if (radix == 16 && c >= "A" && c <= "F") d = int'(c - "A") + 10;
    else if (radix == 16 && c >= "a" && c <= "f") d = int'(c - "a") + 10;
    if (d >= int'(radix)) d = -1;
    return d;
  endfunction

  function automatic bit close_number(output amrnp_pkg::out_word_t r,
                                      input logic [31:0] v,
                                      input amrnp_pkg::status_e s,
                                      input logic [7:0] off);
    r.value       = v;
    r.status      = s;
    r.next_offset = off;
    number_phase  = amrnp_pkg::PH_DONE;
    return 1'b1;
  endfunction

  // Advance the parser by one character; return 1 when it closes a number.
  function automatic bit parse_char(input amrnp_pkg::in_word_t w,
                                    output amrnp_pkg::out_word_t r);
    logic [7:0]  c;
    logic [7:0]  p;
    int unsigned radix;
    int          dv;
    bit          ovf;
    c = w.character;
    r = '0;
    if (w.start_of_text) begin
      number_phase = amrnp_pkg::PH_SKIP;
      number_acc   = '0;
      text_pos     = '0;
      have_digit   = 1'b0;
    end
    if (number_phase == amrnp_pkg::PH_IDLE || number_phase == amrnp_pkg::PH_DONE) return 1'b0;
    p = text_pos;
    if (text_pos < OffsetCap) text_pos++;

    if (number_phase == amrnp_pkg::PH_SKIP) begin
      if (c == 8'h00) return close_number(r, '0, amrnp_pkg::ST_NONUM, '0);
      if (c <= 8'h20) return 1'b0;
      if (c == "0") begin
        number_phase = amrnp_pkg::PH_ZERO;
        return 1'b0;
      end
      if (c == "b" || c == "B") begin
        number_phase = amrnp_pkg::PH_BIN;
        have_digit   = 1'b0;
        number_acc   = '0;
        return 1'b0;
      end
      if (c >= "1" && c <= "9") begin
        number_phase = amrnp_pkg::PH_DEC;
        number_acc   = 32'(c - "0");
        have_digit   = 1'b1;
        return 1'b0;
      end
      return close_number(r, '0, amrnp_pkg::ST_NONUM, '0);
    end

    if (number_phase == amrnp_pkg::PH_ZERO) begin
      if (c == "x" || c == "X") begin
        number_phase = amrnp_pkg::PH_HEX;
        have_digit   = 1'b0;
        number_acc   = '0;
        return 1'b0;
      end
      if (c >= "0" && c <= "7") begin
        number_phase = amrnp_pkg::PH_OCT;
        number_acc   = 32'(c - "0");
        have_digit   = 1'b1;
        return 1'b0;
      end
      return close_number(r, '0, amrnp_pkg::ST_OK, p);
    end

    case (number_phase)
      amrnp_pkg::PH_HEX: radix = 16;
      amrnp_pkg::PH_OCT: radix = 8;
      amrnp_pkg::PH_BIN: radix = 2;
      default:           radix = 10;
    endcase
    dv = digit_of_char(c, radix);
    if (dv < 0) begin
      if (!have_digit) return close_number(r, '0, amrnp_pkg::ST_NONUM, '0);
      return close_number(r, number_acc, amrnp_pkg::ST_OK, p);
    end
    case (radix)
      16:      ovf = (number_acc & amrnp_pkg::HexMask) != '0;
      8:       ovf = (number_acc & amrnp_pkg::OctMask) != '0;
      2:       ovf = (number_acc & amrnp_pkg::BinMask) != '0;
      default: ovf = number_acc > amrnp_pkg::DecLimit ||
                     (number_acc == amrnp_pkg::DecLimit && dv > 5);
    endcase
    if (ovf) return close_number(r, amrnp_pkg::OvfValue, amrnp_pkg::ST_OVF, '0);
    number_acc = 32'(number_acc * radix + 32'(dv));
    have_digit = 1'b1;
    return 1'b0;
  endfunction

  // predict on every accepted word
  always @(posedge clk_i) begin : accept_monitor
    amrnp_pkg::out_word_t predicted;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (parse_char(in_word_i, predicted)) expected_results.push_back(predicted);
    end
  end

  always @(posedge clk_i) begin : result_check
    amrnp_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: value=%h status=%0d next_offset=%0d",
               out_word_o.value, out_word_o.status, out_word_o.next_offset);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_word_o.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, out_word_o.value);
          error_count++;
        end
        if (out_word_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word_o.status);
          error_count++;
        end
        if (out_word_o.next_offset !== want.next_offset) begin
          $error("next_offset: expected %0d, got %0d",
                 want.next_offset, out_word_o.next_offset);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(input logic sof, input logic [7:0] ch);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{start_of_text: sof, character: ch};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(input text_q_t text);
    foreach (text[i]) send_word(i == 0, text[i]);
  endtask

  task automatic send_string(input string s, input bit with_nul);
    text_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    if (with_nul) text.push_back(8'h00);
    send_text(text);
  endtask

  function automatic text_q_t random_text();
    text_q_t     text;
    string       threshold;
    int unsigned shape;
    int unsigned ndigits;
    bit          all_max;
    shape     = $urandom_range(99);
    all_max   = ($urandom_range(3) == 0);
    threshold = "429496729";
    repeat ($urandom_range(3)) text.push_back(8'($urandom_range(1, 32)));
    if (shape < 12) begin
      // straddle the decimal overflow threshold
      for (int i = 0; i < threshold.len(); i++) text.push_back(threshold[i]);
      text.push_back(8'("0" + $urandom_range(4, 7)));
      if ($urandom_range(1)) text.push_back(8'("0" + $urandom_range(9)));
    end else begin
      case ($urandom_range(4))
        0: begin
          text.push_back(8'("1" + $urandom_range(8)));
          ndigits = $urandom_range(10);
          repeat (ndigits) text.push_back(all_max ? "9" : 8'("0" + $urandom_range(9)));
        end
        1: begin
          text.push_back("0");
          text.push_back($urandom_range(1) ? "x" : "X");
          ndigits = $urandom_range(9);
          repeat (ndigits) begin
            if (all_max) text.push_back($urandom_range(1) ? "f" : "F");
            else text.push_back(HexDigits[$urandom_range(21)]);
          end
        end
        2: begin
          text.push_back("0");
          ndigits = $urandom_range(12);
          repeat (ndigits) text.push_back(all_max ? "7" : 8'("0" + $urandom_range(7)));
        end
        3: begin
          text.push_back($urandom_range(1) ? "b" : "B");
          ndigits = $urandom_range(34);
          repeat (ndigits) text.push_back(all_max ? "1" : 8'("0" + $urandom_range(1)));
        end
        default: text.push_back("0");
      endcase
    end
    // leave the text open so the next start drops it
    if (shape >= 90) return text;
    if ($urandom_range(1)) text.push_back(8'h00);
    else text.push_back(8'($urandom));
    repeat ($urandom_range(2)) text.push_back(8'($urandom));
    return text;
  endfunction

  task automatic test_bytes_before_start();
    send_word(1'b0, "x");
  endtask

  task automatic test_prefix_cases();
    send_string("\t0xFf,", 1'b0);
    send_string("b101", 1'b1);
    send_string("017 8", 1'b0);
    send_string("09", 1'b0);
    send_string("0x", 1'b1);
    // restart in the middle of a number
    send_string("12", 1'b0);
    send_word(1'b1, 8'hFF);
    send_string(" ", 1'b1);
  endtask

  task automatic test_long_text();
    text_q_t text;
    repeat (260) text.push_back(8'($urandom_range(1, 32)));
    text.push_back("1");
    text.push_back("2");
    text.push_back("3");
    text.push_back(8'h00);
    send_text(text);
    text.delete();
    repeat (250) text.push_back(8'($urandom_range(1, 32)));
    text.push_back("0");
    text.push_back("x");
    repeat (6) text.push_back(HexDigits[$urandom_range(21)]);
    text.push_back("g");
    send_text(text);
  endtask

  task automatic test_random_texts(input int unsigned word_budget);
    int unsigned stop_at;
    stop_at = words_sent + word_budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 6)) send_word($urandom_range(3) == 0, 8'($urandom));
      end else begin
        send_text(random_text());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct    = 19;
    receiver_stall_pct = 81;
    test_bytes_before_start();
    test_prefix_cases();
    test_random_texts(250);

    sender_idle_pct    = 81;
    receiver_stall_pct = 19;
    test_random_texts(250);

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_long_text();
    test_random_texts(250);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
